// ===== rtl/msd_pkg.sv =====
// Shared types and constants for the motor stall detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package msd_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int CODE_W     = 12;
    localparam int HOLD_W     = 16;
    localparam int COUNT_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CODE_W-1:0]  THRESHOLD_RESET = 12'd1000;
    localparam logic [HOLD_W-1:0]  HOLD_RESET      = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 17'h1FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_HOLD      = 2'd1
    } cfg_reg_t;

    typedef logic [CODE_W-1:0] code_t;
    typedef code_t [NUM_MOTORS-1:0] code_vec_t;

    // per-cycle control from the sequencer to every lane
    typedef struct packed {
        logic wr_en;
        logic clr_peak;
        logic rd_en;
        logic rd_live;
    } lane_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_MERGE = 4'b1000
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/msd_lane.sv =====
// One motor lane: absolute difference, circular window memory, serial max scan.
// Depends on msd_pkg.
`default_nettype none

module msd_lane #(
    parameter int WINDOW_DEPTH = 16,
    parameter int AW           = 4
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  msd_pkg::lane_ctrl_t  ctrl,
    input  msd_pkg::code_t       ref_code,
    input  msd_pkg::code_t       out_code,
    input  wire [AW-1:0]         wr_addr,
    input  wire [AW-1:0]         rd_addr,
    output msd_pkg::code_t       peak
);
    import msd_pkg::*;

    code_t mem [WINDOW_DEPTH];
    code_t diff;
    code_t rd_data_reg;
    code_t peak_reg;
    logic  hit_reg;

    assign diff = (out_code > ref_code) ? (out_code - ref_code) : (ref_code - out_code);

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= diff;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= ctrl.rd_en & ctrl.rd_live;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clr_peak) begin
            peak_reg <= '0;
        end else if (hit_reg && (rd_data_reg > peak_reg)) begin
            peak_reg <= rd_data_reg;
        end
    end

    assign peak = peak_reg;

endmodule

`default_nettype wire

// ===== rtl/msd_merge.sv =====
// Merge stage: threshold compare over lane peaks, hysteresis counters, result register.
// Depends on msd_pkg.
`default_nettype none

module msd_merge (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        load,
    input  msd_pkg::code_vec_t         peaks,
    input  msd_pkg::code_t             threshold,
    input  wire [msd_pkg::HOLD_W-1:0]  hold,
    input  wire                        m_ready,
    output logic                       out_free,
    output logic                       m_valid,
    output msd_pkg::code_vec_t         m_peaks,
    output logic                       m_any_above,
    output logic                       m_locked
);
    import msd_pkg::*;

    logic [COUNT_W-1:0] above_cnt_reg, above_cnt_next;
    logic [COUNT_W-1:0] below_cnt_reg, below_cnt_next;
    logic [COUNT_W-1:0] above_inc, below_inc, hold_ext;
    logic               locked_reg, locked_next;
    logic               valid_reg, valid_next;
    logic               above;
    code_vec_t          peaks_reg;
    logic               any_above_reg;

    always_comb begin
        above = 1'b0;
        for (int m = 0; m < NUM_MOTORS; m++) begin
            if (peaks[m] > threshold) begin
                above = 1'b1;
            end
        end
    end

    assign hold_ext  = {1'b0, hold};
    assign above_inc = (above_cnt_reg == COUNT_MAX) ? above_cnt_reg : above_cnt_reg + 1'b1;
    assign below_inc = (below_cnt_reg == COUNT_MAX) ? below_cnt_reg : below_cnt_reg + 1'b1;

    always_comb begin
        above_cnt_next = above_cnt_reg;
        below_cnt_next = below_cnt_reg;
        locked_next    = locked_reg;
        if (load) begin
            if (above) begin
                above_cnt_next = above_inc;
                if (above_inc > hold_ext) begin
                    below_cnt_next = '0;
                    locked_next    = 1'b1;
                end
            end else begin
                below_cnt_next = below_inc;
                if (below_inc > hold_ext) begin
                    above_cnt_next = '0;
                    locked_next    = 1'b0;
                end
            end
        end
    end

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_cnt_reg <= '0;
            below_cnt_reg <= '0;
            locked_reg    <= 1'b0;
            valid_reg     <= 1'b0;
        end else begin
            above_cnt_reg <= above_cnt_next;
            below_cnt_reg <= below_cnt_next;
            locked_reg    <= locked_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            peaks_reg     <= peaks;
            any_above_reg <= above;
        end
    end

    assign m_valid     = valid_reg;
    assign m_peaks     = peaks_reg;
    assign m_any_above = any_above_reg;
    assign m_locked    = locked_reg;

endmodule

`default_nettype wire

// ===== rtl/motor_stall_detector.sv =====
// Motor stall detector: four lanes scan their sample windows, merge stage judges lock.
// An item is accepted only when idle; it passes the scan, drain and merge states before m_valid.
// No new item is taken until the merge loads the result; the window scan reads one entry a cycle.
// Reset: aresetn synchronous active low; windows read as zero until written (fill count),
// counters and locked flag cleared, threshold and hold count return to 1000.
`default_nettype none

module motor_stall_detector #(
    parameter int WINDOW_DEPTH = 16
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_we,
    input  wire [msd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [msd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire [msd_pkg::CODE_W-1:0]      s_ref_m1,
    input  wire [msd_pkg::CODE_W-1:0]      s_out_m1,
    input  wire [msd_pkg::CODE_W-1:0]      s_ref_m2,
    input  wire [msd_pkg::CODE_W-1:0]      s_out_m2,
    input  wire [msd_pkg::CODE_W-1:0]      s_ref_m3,
    input  wire [msd_pkg::CODE_W-1:0]      s_out_m3,
    input  wire [msd_pkg::CODE_W-1:0]      s_ref_m4,
    input  wire [msd_pkg::CODE_W-1:0]      s_out_m4,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic [msd_pkg::CODE_W-1:0]     m_peak_m1,
    output logic [msd_pkg::CODE_W-1:0]     m_peak_m2,
    output logic [msd_pkg::CODE_W-1:0]     m_peak_m3,
    output logic [msd_pkg::CODE_W-1:0]     m_peak_m4,
    output logic                           m_any_above,
    output logic                           m_locked
);
    import msd_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);
    localparam logic [FW-1:0] FULL     = FW'(WINDOW_DEPTH);

    seq_state_t    state_reg, state_next;
    logic [AW-1:0] wr_pos_reg, wr_pos_next;
    logic [AW-1:0] scan_idx_reg, scan_idx_next;
    logic [FW-1:0] fill_reg, fill_next;
    code_t         threshold_reg;
    logic [HOLD_W-1:0] hold_reg;
    lane_ctrl_t    ctrl;
    logic          accept;
    logic          out_free;
    logic          load;
    code_vec_t     ref_vec, out_vec, peaks, m_peaks;

    assign ref_vec = {s_ref_m4, s_ref_m3, s_ref_m2, s_ref_m1};
    assign out_vec = {s_out_m4, s_out_m3, s_out_m2, s_out_m1};

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign load    = (state_reg == ST_MERGE) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            hold_reg      <= HOLD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_wdata[CODE_W-1:0];
                REG_HOLD:      hold_reg      <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        wr_pos_next   = wr_pos_reg;
        scan_idx_next = scan_idx_reg;
        fill_next     = fill_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    wr_pos_next   = (wr_pos_reg == LAST_IDX) ? '0 : wr_pos_reg + 1'b1;
                    fill_next     = (fill_reg == FULL) ? fill_reg : fill_reg + 1'b1;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wr_pos_reg   <= '0;
            scan_idx_reg <= '0;
            fill_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            wr_pos_reg   <= wr_pos_next;
            scan_idx_reg <= scan_idx_next;
            fill_reg     <= fill_next;
        end
    end

    // entries at or past the fill count were never written and read as zero
    always_comb begin
        ctrl.wr_en    = accept;
        ctrl.clr_peak = accept;
        ctrl.rd_en    = (state_reg == ST_SCAN);
        ctrl.rd_live  = FW'(scan_idx_reg) < fill_reg;
    end

    for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_lane
        msd_lane #(
            .WINDOW_DEPTH (WINDOW_DEPTH),
            .AW           (AW)
        ) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .ref_code (ref_vec[m]),
            .out_code (out_vec[m]),
            .wr_addr  (wr_pos_reg),
            .rd_addr  (scan_idx_reg),
            .peak     (peaks[m])
        );
    end

    msd_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .peaks       (peaks),
        .threshold   (threshold_reg),
        .hold        (hold_reg),
        .m_ready     (m_ready),
        .out_free    (out_free),
        .m_valid     (m_valid),
        .m_peaks     (m_peaks),
        .m_any_above (m_any_above),
        .m_locked    (m_locked)
    );

    assign m_peak_m1 = m_peaks[0];
    assign m_peak_m2 = m_peaks[1];
    assign m_peak_m3 = m_peaks[2];
    assign m_peak_m4 = m_peaks[3];

endmodule

`default_nettype wire

// ===== rtl/msd_checker.sv =====
// Port-level checks for motor_stall_detector, attached by bind.
// Depends on msd_pkg and the top level's port list.
`default_nettype none

module msd_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_valid,
    input wire                           s_ready,
    input wire                           m_valid,
    input wire                           m_ready,
    input wire [msd_pkg::CODE_W-1:0]     m_peak_m1,
    input wire [msd_pkg::CODE_W-1:0]     m_peak_m2,
    input wire [msd_pkg::CODE_W-1:0]     m_peak_m3,
    input wire [msd_pkg::CODE_W-1:0]     m_peak_m4,
    input wire                           m_any_above,
    input wire                           m_locked
);
    import msd_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in the window scan");

    a_zero_peaks_below: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_peak_m1 == '0) && (m_peak_m2 == '0) &&
        (m_peak_m3 == '0) && (m_peak_m4 == '0) |-> !m_any_above)
        else $error("above flag with all peaks zero");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_peak_m1) && $stable(m_any_above)
                                && $stable(m_locked))
        else $error("stalled result changed");

endmodule

bind motor_stall_detector msd_checker u_msd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_peak_m1   (m_peak_m1),
    .m_peak_m2   (m_peak_m2),
    .m_peak_m3   (m_peak_m3),
    .m_peak_m4   (m_peak_m4),
    .m_any_above (m_any_above),
    .m_locked    (m_locked)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for motor_stall_detector: drives sample items, predicts
// peaks, threshold flag and lock state, and compares every result. Needs msd_pkg.
module tb;
    import msd_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        code_vec_t ref_code;
        code_vec_t out_code;
    } sample_t;

    typedef struct packed {
        code_vec_t peak;
        logic      above;
        logic      locked;
    } stall_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    code_t s_ref_m1 = '0, s_out_m1 = '0, s_ref_m2 = '0, s_out_m2 = '0;
    code_t s_ref_m3 = '0, s_out_m3 = '0, s_ref_m4 = '0, s_out_m4 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    code_t m_peak_m1, m_peak_m2, m_peak_m3, m_peak_m4;
    logic m_any_above;
    logic m_locked;

    // predictor state and register copies
    code_t diff_win [NUM_MOTORS][DEPTH] = '{default: '0};
    int unsigned wr_pos [NUM_MOTORS] = '{default: 0};
    logic [COUNT_W-1:0] above_cnt = '0;
    logic [COUNT_W-1:0] below_cnt = '0;
    logic lock_flag = 1'b0;
    code_t thr_reg = THRESHOLD_RESET;
    logic [HOLD_W-1:0] hold_reg = HOLD_RESET;

    sample_t pending_items[$];
    stall_result_t expected_results[$];
    sample_t next_item;
    sample_t taken_item;
    stall_result_t got_result;
    stall_result_t want_result;

    int unsigned send_idle_pct = 6;
    int unsigned recv_idle_pct = 56;
    int unsigned send_calm = 0;
    int unsigned recv_calm = 0;
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;

    motor_stall_detector #(.WINDOW_DEPTH(DEPTH)) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ref_m1   (s_ref_m1),
        .s_out_m1   (s_out_m1),
        .s_ref_m2   (s_ref_m2),
        .s_out_m2   (s_out_m2),
        .s_ref_m3   (s_ref_m3),
        .s_out_m3   (s_out_m3),
        .s_ref_m4   (s_ref_m4),
        .s_out_m4   (s_out_m4),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_peak_m1  (m_peak_m1),
        .m_peak_m2  (m_peak_m2),
        .m_peak_m3  (m_peak_m3),
        .m_peak_m4  (m_peak_m4),
        .m_any_above(m_any_above),
        .m_locked   (m_locked)
    );

    always #5 aclk = ~aclk;

    function automatic stall_result_t predict_stall(sample_t smp);
        stall_result_t r;
        code_t d;
        code_t pk;
        logic hot;
        hot = 1'b0;
        for (int m = 0; m < NUM_MOTORS; m++) begin
            d = (smp.out_code[m] > smp.ref_code[m]) ? smp.out_code[m] - smp.ref_code[m]
                                                    : smp.ref_code[m] - smp.out_code[m];
            diff_win[m][wr_pos[m]] = d;
            wr_pos[m] = (wr_pos[m] + 1) % DEPTH;
            pk = '0;
            for (int i = 0; i < DEPTH; i++) begin
                if (diff_win[m][i] > pk) begin
                    pk = diff_win[m][i];
                end
            end
            r.peak[m] = pk;
            if (pk > thr_reg) begin
                hot = 1'b1;
            end
        end
        if (hot) begin
            if (above_cnt != COUNT_MAX) begin
                above_cnt = above_cnt + 1'b1;
            end
            if (above_cnt > {1'b0, hold_reg}) begin
                below_cnt = '0;
                lock_flag = 1'b1;
            end
        end else begin
            if (below_cnt != COUNT_MAX) begin
                below_cnt = below_cnt + 1'b1;
            end
            if (below_cnt > {1'b0, hold_reg}) begin
                above_cnt = '0;
                lock_flag = 1'b0;
            end
        end
        r.above = hot;
        r.locked = lock_flag;
        return r;
    endfunction

    // random stall with occasional stretches of no idling
    function automatic bit gap_roll(input int unsigned pct, inout int unsigned calm);
        if (calm != 0) begin
            calm = calm - 1;
            return 1'b0;
        end
        if ($urandom_range(0, 63) == 0) begin
            calm = $urandom_range(20, 100);
            return 1'b0;
        end
        return $urandom_range(0, 99) < pct;
    endfunction

    // quiet motors stay at or below the threshold; a loud item pushes one or more above it unless the threshold is 4095
    function automatic sample_t shaped_sample(bit loud);
        sample_t s;
        int unsigned d, base, lo, hot_m;
        lo = thr_reg;
        lo = lo + 1;
        if (lo > 4095) begin
            lo = 4095;
        end
        hot_m = $urandom_range(0, NUM_MOTORS - 1);
        for (int m = 0; m < NUM_MOTORS; m++) begin
            d = $urandom_range(0, thr_reg >> $urandom_range(0, 6));
            if (loud && (m == hot_m || $urandom_range(0, 3) == 0)) begin
                d = $urandom_range(lo, 4095);
            end
            base = $urandom_range(0, 4095 - d);
            if ($urandom_range(0, 1) == 1) begin
                s.ref_code[m] = code_t'(base);
                s.out_code[m] = code_t'(base + d);
            end else begin
                s.ref_code[m] = code_t'(base + d);
                s.out_code[m] = code_t'(base);
            end
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d expected %0d (result %0d)",
                 what, got, want, results_seen);
        errors++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_reg = val[CODE_W-1:0];
            REG_HOLD: hold_reg = val;
            default: ;
        endcase
    endtask

    task automatic push_pair(logic [NUM_MOTORS-1:0] mask, code_t r, code_t o);
        sample_t s;
        s = '0;
        for (int m = 0; m < NUM_MOTORS; m++) begin
            if (mask[m]) begin
                s.ref_code[m] = r;
                s.out_code[m] = o;
            end
        end
        pending_items.push_back(s);
    endtask

    task automatic fill_random(int n);
        int left, run, kind;
        sample_t s;
        left = n;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                run = $urandom_range(1, 6);
            end else if (kind < 5) begin
                run = $urandom_range(1, 25);
            end else begin
                run = $urandom_range(1, 60);
            end
            if (run > left) begin
                run = left;
            end
            repeat (run) begin
                if (kind == 0) begin
                    s = {$urandom(), $urandom(), $urandom()};
                end else begin
                    s = shaped_sample(kind < 5);
                end
                pending_items.push_back(s);
            end
            left -= run;
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] hold,
                             int n, int unsigned s_pct, int unsigned r_pct);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_HOLD, hold);
        @(negedge aclk);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        fill_random(n);
        wait_drained();
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() != 0 && !gap_roll(send_idle_pct, send_calm)) begin
                next_item = pending_items.pop_front();
                s_valid <= 1'b1;
                s_ref_m1 <= next_item.ref_code[0];
                s_out_m1 <= next_item.out_code[0];
                s_ref_m2 <= next_item.ref_code[1];
                s_out_m2 <= next_item.out_code[1];
                s_ref_m3 <= next_item.ref_code[2];
                s_out_m3 <= next_item.out_code[2];
                s_ref_m4 <= next_item.ref_code[3];
                s_out_m4 <= next_item.out_code[3];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !gap_roll(recv_idle_pct, recv_calm);
        end
    end

    // monitor: check results first, then predict for the item taken at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding", 0, 0);
                end else begin
                    want_result = expected_results.pop_front();
                    got_result.peak = {m_peak_m4, m_peak_m3, m_peak_m2, m_peak_m1};
                    got_result.above = m_any_above;
                    got_result.locked = m_locked;
                    for (int m = 0; m < NUM_MOTORS; m++) begin
                        if (got_result.peak[m] !== want_result.peak[m]) begin
                            report_mismatch($sformatf("peak_m%0d", m + 1),
                                            got_result.peak[m], want_result.peak[m]);
                        end
                    end
                    if (got_result.above !== want_result.above) begin
                        report_mismatch("any_above", got_result.above, want_result.above);
                    end
                    if (got_result.locked !== want_result.locked) begin
                        report_mismatch("locked", got_result.locked, want_result.locked);
                    end
                end
            end
            if (s_valid && s_ready) begin
                taken_item.ref_code = {s_ref_m4, s_ref_m3, s_ref_m2, s_ref_m1};
                taken_item.out_code = {s_out_m4, s_out_m3, s_out_m2, s_out_m1};
                expected_results.push_back(predict_stall(taken_item));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset register values, threshold edges, code extremes, then a window flush
        push_pair(4'b1111, 12'd0, 12'd0);
        push_pair(4'b0001, 12'd1000, 12'd0);
        push_pair(4'b0010, 12'd0, 12'd1001);
        push_pair(4'b0100, 12'hFFF, 12'd0);
        push_pair(4'b1000, 12'd0, 12'hFFF);
        push_pair(4'b1111, 12'hFFF, 12'hFFF);
        push_pair(4'b1111, 12'hAAA, 12'h555);
        push_pair(4'b1111, 12'h555, 12'hAAA);
        repeat (DEPTH) push_pair(4'b1111, 12'h7FF, 12'h7FF);
        wait_drained();

        // upper bits of the threshold write are dropped; zero hold locks at once
        run_phase(16'hF000, 16'd0, 150, 6, 56);
        write_reg(REG_SPARE, 16'h1234);
        run_phase(16'hFFFF, 16'hFFFF, 100, 6, 56);
        run_phase(16'd500, 16'd3, 300, 56, 6);
        run_phase(16'd2000, 16'd10, 300, 0, 0);
        run_phase(16'd1000, 16'd1, 400, 0, 0);

        repeat (4 * DEPTH) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/msd_pkg.sv
rtl/msd_lane.sv
rtl/msd_merge.sv
rtl/motor_stall_detector.sv
rtl/msd_checker.sv
tb/sv/tb.sv
